// ----- design/pair_word_alu_defines.svh -----
// ----------------------------------------------------------------------------
// pair_word_alu_defines.svh - assertion macros
// Shorthand for the concurrent checks on the ALU ports, sampled on clk.
// ----------------------------------------------------------------------------
`ifndef PAIR_WORD_ALU_DEFINES_SVH
`define PAIR_WORD_ALU_DEFINES_SVH

// same-cycle implication, off while rst_n is low
`define PWA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while rst_n is low
`define PWA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds through reset
`define PWA_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/pwa_pkg.sv -----
// ----------------------------------------------------------------------------
// pwa_pkg - shared constants of the pair word ALU
// Operation codes, field widths and default parameter values.
// ----------------------------------------------------------------------------
package pwa_pkg;

  localparam int WORD_WIDTH_DEF = 16;
  localparam int MODE_W         = 4;
  localparam int SHAMT_W        = 4;
  localparam int BYTE_W         = 8;
  localparam int NUM_WORDS      = 4;

  localparam logic [MODE_W-1:0] OP_NOP  = 4'd0;
  localparam logic [MODE_W-1:0] OP_ADD  = 4'd1;
  localparam logic [MODE_W-1:0] OP_SUB  = 4'd2;
  localparam logic [MODE_W-1:0] OP_SLT  = 4'd3;
  localparam logic [MODE_W-1:0] OP_AND  = 4'd4;
  localparam logic [MODE_W-1:0] OP_OR   = 4'd5;
  localparam logic [MODE_W-1:0] OP_NOR  = 4'd6;
  localparam logic [MODE_W-1:0] OP_XOR  = 4'd7;
  localparam logic [MODE_W-1:0] OP_LUI  = 4'd8;
  localparam logic [MODE_W-1:0] OP_LLI  = 4'd9;
  localparam logic [MODE_W-1:0] OP_SHL  = 4'd10;
  localparam logic [MODE_W-1:0] OP_SRA  = 4'd11;
  localparam logic [MODE_W-1:0] OP_SHR  = 4'd12;
  localparam logic [MODE_W-1:0] OP_PICK = 4'd13;
  localparam logic [MODE_W-1:0] OP_EXCH = 4'd14;

endpackage

// ----- design/pwa_alu.sv -----
// ----------------------------------------------------------------------------
// pwa_alu - combinational datapath of the pair word ALU
// One 2W-bit adder for add/sub/slt, logic, byte loads, a barrel shifter and word pick/exchange.
// ----------------------------------------------------------------------------
module pwa_alu
  import pwa_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic [MODE_W-1:0]     mode,
  input  logic [WORD_WIDTH-1:0] a0,
  input  logic [WORD_WIDTH-1:0] a1,
  input  logic [WORD_WIDTH-1:0] b0,
  input  logic [WORD_WIDTH-1:0] b1,
  output logic [WORD_WIDTH-1:0] r0,
  output logic [WORD_WIDTH-1:0] r1,
  output logic [WORD_WIDTH-1:0] r2,
  output logic [WORD_WIDTH-1:0] r3
);

  localparam int PAIR_W = 2 * WORD_WIDTH;

  logic [PAIR_W-1:0]    pa;
  logic [PAIR_W-1:0]    pb_eff;
  logic [PAIR_W-1:0]    sum;
  logic                 do_add;
  logic [SHAMT_W:0]     amt;
  logic [WORD_WIDTH-1:0] shl_res;
  logic [WORD_WIDTH-1:0] shr_res;
  logic [WORD_WIDTH-1:0] sra_res;

  assign pa     = {a0, a1};
  assign do_add = (mode == OP_ADD);
  // subtract as add of the complement plus one
  assign pb_eff = do_add ? {b0, b1} : ~{b0, b1};
  assign sum    = pa + pb_eff + {{(PAIR_W-1){1'b0}}, ~do_add};

  assign amt     = {1'b0, b0[SHAMT_W-1:0]} + {{SHAMT_W{1'b0}}, 1'b1};
  assign shl_res = a0 << amt;
  assign shr_res = a0 >> amt;
  assign sra_res = WORD_WIDTH'($signed(a0) >>> amt);

  always_comb begin
    r0 = a0;
    r1 = a1;
    r2 = b0;
    r3 = b1;
    unique case (mode) inside
      OP_ADD, OP_SUB: begin
        r0 = sum[PAIR_W-1:WORD_WIDTH];
        r1 = sum[WORD_WIDTH-1:0];
      end
      OP_SLT:  r0 = {{(WORD_WIDTH-1){1'b0}}, sum[PAIR_W-1]};
      OP_AND:  r0 = a0 & b0;
      OP_OR:   r0 = a0 | b0;
      OP_NOR:  r0 = ~(a0 | b0);
      OP_XOR:  r0 = a0 ^ b0;
      OP_LUI:  r0 = {b0[WORD_WIDTH-BYTE_W-1:0], {BYTE_W{1'b0}}};
      OP_LLI:  r0 = {{(WORD_WIDTH-BYTE_W){1'b0}}, b0[BYTE_W-1:0]};
      OP_SHL:  r0 = shl_res;
      OP_SHR:  r0 = shr_res;
      OP_SRA:  r0 = sra_res;
      OP_PICK: begin
        r0 = b0;
        r1 = b1;
      end
      OP_EXCH: begin
        r0 = b0;
        r1 = b1;
        r2 = a0;
        r3 = a1;
      end
      default: ; // nop and the unused code pass all words through
    endcase
  end

endmodule

// ----- design/pair_word_alu.sv -----
// ----------------------------------------------------------------------------
// pair_word_alu - execute-stage ALU of a 16-bit register machine
// Registers an operation and four operand words, computes in one pass and
// holds the four result words in an output register.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | beat carries
//  ---------+-----------------------------------------+----------------------
//  input    | in_tvalid, in_tready, in_tdata, in_tuser | mode + four words
//  result   | out_tvalid, out_tready, out_tdata       | four result words
//
//  One beat per cycle in and out, sustained while out_tready stays high. A
//  beat passes the input register, the ALU and the result register, and
//  out_tvalid rises once the result register has loaded it.
//  rst_n (synchronous, active low) empties both stages.
//  A stall on out_tready holds the result register; the input register
//  still fills, and in_tready drops only once both stages are full.
// ----------------------------------------------------------------------------
module pair_word_alu
  import pwa_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [W-1:0] in_word0, [2W-1:W] in_word1, [3W-1:2W] in_word2, [4W-1:3W] in_word3
  input  logic [NUM_WORDS*WORD_WIDTH-1:0] in_tdata,
  // [3:0] mode
  input  logic [MODE_W-1:0]               in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [W-1:0] out_word0, [2W-1:W] out_word1, [3W-1:2W] out_word2,
  // [4W-1:3W] out_word3
  output logic [NUM_WORDS*WORD_WIDTH-1:0] out_tdata
);

  localparam int W = WORD_WIDTH;

  logic                   in_vld_r;
  logic [MODE_W-1:0]      mode_r;
  logic [NUM_WORDS*W-1:0] opnd_r;
  logic                   out_vld_r;
  logic [NUM_WORDS*W-1:0] res_r;
  logic [NUM_WORDS*W-1:0] res_nxt;
  logic                   res_load;

  // result register takes a beat when empty or being drained this cycle
  assign res_load  = in_vld_r && (!out_vld_r || out_tready);
  // input register frees when its beat moves on
  assign in_tready = !in_vld_r || res_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (res_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload: capture on acceptance, hold otherwise
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r <= in_tuser;
      opnd_r <= in_tdata;
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  pwa_alu #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_alu (
    .mode (mode_r),
    .a0   (opnd_r[W-1:0]),
    .a1   (opnd_r[2*W-1:W]),
    .b0   (opnd_r[3*W-1:2*W]),
    .b1   (opnd_r[4*W-1:3*W]),
    .r0   (res_nxt[W-1:0]),
    .r1   (res_nxt[2*W-1:W]),
    .r2   (res_nxt[3*W-1:2*W]),
    .r3   (res_nxt[4*W-1:3*W])
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = res_r;

endmodule

// ----- design/pwa_checker.sv -----
// ----------------------------------------------------------------------------
// pwa_checker - port-level checks of the pair word ALU
// Watches the two stream channels for reset, flow and latency behavior.
// ----------------------------------------------------------------------------
`include "pair_word_alu_defines.svh"

module pwa_checker
  import pwa_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [NUM_WORDS*WORD_WIDTH-1:0] in_tdata,
  input logic [MODE_W-1:0]               in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [NUM_WORDS*WORD_WIDTH-1:0] out_tdata
);

  logic in_beat;
  logic in_stall;
  logic out_stall;
  assign in_beat   = in_tvalid && in_tready;
  assign in_stall  = in_tvalid && !in_tready;
  assign out_stall = out_tvalid && !out_tready;

  `PWA_ASSERT_RST(a_rst_empty, !rst_n, !out_tvalid, "result valid after reset")
  `PWA_ASSERT_NXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata), "stalled result changed")
  `PWA_ASSERT_NXT(a_in_hold, in_stall, in_tvalid && $stable({in_tuser, in_tdata}), "input changed")
  `PWA_ASSERT_IMP(a_ready_empty, !out_tvalid, in_tready, "not ready with empty output")
  `PWA_ASSERT_IMP(a_latency, $rose(out_tvalid), $past(in_beat, 2), "result without input")

endmodule

bind pair_word_alu pwa_checker #(.WORD_WIDTH(WORD_WIDTH)) u_pwa_checker (.*);
